// ===== rtl/dlu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Dwell lock/unlock qualifier package
// Shared widths, reset values, codes and the command that the front end
// hands to the back end through the queue.
// ---------------------------------------------------------------------------
package dlu_pkg;

  // Field widths fixed by the interface.
  localparam int MASK_W     = 16;
  localparam int TICK_W     = 16;
  localparam int TIME_W     = 24;
  localparam int SLOT_OUT_W = 4;
  localparam int KIND_W     = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TIME_W;

  localparam logic [CFG_IDX_W-1:0] REG_LOCK_TIME   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_TIME = 1'b1;

  localparam logic [TIME_W-1:0] LOCK_TIME_RST   = 24'd1000;
  localparam logic [TIME_W-1:0] UNLOCK_TIME_RST = 24'd1000;

  // Default number of slots and depth of the command queue.
  localparam int SLOT_COUNT_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;

  // Per-slot status.
  typedef enum logic [1:0] {
    ST_IDLE        = 2'd0,
    ST_WAIT_LOCK   = 2'd1,
    ST_LOCKED      = 2'd2,
    ST_WAIT_UNLOCK = 2'd3
  } status_t;

  // Phases of one tick, in the order their events leave the block.
  typedef enum logic [1:0] {
    PH_START_LOCK   = 2'd0,
    PH_LOCK         = 2'd1,
    PH_START_UNLOCK = 2'd2,
    PH_UNLOCK       = 2'd3
  } phase_t;

  // Event codes on the result channel.
  typedef enum logic [KIND_W-1:0] {
    EV_START_LOCK    = 3'd0,
    EV_LOCKING       = 3'd1,
    EV_FINISH_LOCK   = 3'd2,
    EV_START_UNLOCK  = 3'd3,
    EV_UNLOCKING     = 3'd4,
    EV_FINISH_UNLOCK = 3'd5
  } event_kind_t;

  // One unit of work for the back end: exactly one event comes out of it.
  typedef struct packed {
    phase_t                phase;
    logic                  present;
    logic                  last;
    logic [SLOT_OUT_W-1:0] slot;
  } cmd_t;

  // Tick start notice from the front end to the back end.
  typedef struct packed {
    logic              go;
    logic [TICK_W-1:0] dt;
  } start_t;

endpackage

`default_nettype wire

// ===== rtl/dlu_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Tick input channel
// Valid/ready channel that carries one presence mask and tick time.
// ---------------------------------------------------------------------------
interface dlu_in_if;

  logic                       valid;
  logic                       ready;
  logic [dlu_pkg::MASK_W-1:0] present_mask;
  logic [dlu_pkg::TICK_W-1:0] tick_time;

  modport source (output valid, output present_mask, output tick_time, input ready);
  modport sink   (input valid, input present_mask, input tick_time, output ready);

endinterface

`default_nettype wire

// ===== rtl/dlu_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Event output channel
// Valid/ready channel that carries one slot event.
// ---------------------------------------------------------------------------
interface dlu_out_if;

  logic                           valid;
  logic                           ready;
  logic [dlu_pkg::SLOT_OUT_W-1:0] slot;
  logic [dlu_pkg::KIND_W-1:0]     event_kind;
  logic [dlu_pkg::TIME_W-1:0]     elapsed;
  logic                           last;

  modport source (output valid, output slot, output event_kind, output elapsed,
                  output last, input ready);
  modport sink   (input valid, input slot, input event_kind, input elapsed,
                  input last, output ready);

endinterface

`default_nettype wire

// ===== rtl/dlu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Command queue
// Small FIFO of slot commands between the classifier and the executor.
// ---------------------------------------------------------------------------
module dlu_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  dlu_pkg::cmd_t      push_cmd,
  output logic               full,
  input  wire logic          pop,
  output dlu_pkg::cmd_t      pop_cmd,
  output logic               empty
);

  localparam int Depth = dlu_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  dlu_pkg::cmd_t        entry_r [Depth];
  logic [PtrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]      count_r,  count_nxt;
  logic                 do_push, do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dlu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Tick classifier
// Accepts a tick, sorts the slots into the four phases from the status at
// the start of the tick, and issues one command per event in output order.
// ---------------------------------------------------------------------------
module dlu_front #(
  parameter int SLOT_COUNT = dlu_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  dlu_in_if.sink                       in_chan,
  input  dlu_pkg::status_t [SLOT_COUNT-1:0] slot_status,
  input  wire logic                    back_idle,
  output dlu_pkg::start_t              start,
  output logic [SLOT_COUNT-1:0]        cancel,
  output logic                         q_push,
  output dlu_pkg::cmd_t                q_cmd,
  input  wire logic                    q_full
);

  localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [3:0][SLOT_COUNT-1:0] mask_r, mask_nxt, mask_new;
  logic [SLOT_COUNT-1:0]      pres_r, pres;
  logic [3:0][SlotW-1:0]      low_idx;
  logic [3:0]                 hit;
  dlu_pkg::phase_t            sel_ph;
  logic [SlotW-1:0]           sel_idx;
  logic                       busy, accept;

  assign busy          = |mask_r;
  assign in_chan.ready = !busy && back_idle;
  assign accept        = in_chan.valid && in_chan.ready;
  assign pres          = SLOT_COUNT'(in_chan.present_mask);

  assign start.go = accept;
  assign start.dt = in_chan.tick_time;

  // Phase membership from the status at the start of the tick. A waiting-to-
  // unlock slot that is present again returns to locked without an event.
  always_comb begin
    mask_new = '0;
    cancel   = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      mask_new[dlu_pkg::PH_START_LOCK][i] =
        (slot_status[i] == dlu_pkg::ST_IDLE) && pres[i];
      mask_new[dlu_pkg::PH_LOCK][i] =
        ((slot_status[i] == dlu_pkg::ST_IDLE) && pres[i]) ||
        (slot_status[i] == dlu_pkg::ST_WAIT_LOCK);
      mask_new[dlu_pkg::PH_START_UNLOCK][i] =
        (slot_status[i] == dlu_pkg::ST_LOCKED) && !pres[i];
      mask_new[dlu_pkg::PH_UNLOCK][i] =
        ((slot_status[i] == dlu_pkg::ST_LOCKED) ||
         (slot_status[i] == dlu_pkg::ST_WAIT_UNLOCK)) && !pres[i];
      cancel[i] = accept && (slot_status[i] == dlu_pkg::ST_WAIT_UNLOCK) && pres[i];
    end
  end

  // Lowest pending slot of each phase.
  always_comb begin
    for (int ph = 0; ph < 4; ph++) begin
      hit[ph]     = |mask_r[ph];
      low_idx[ph] = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
        if (mask_r[ph][i]) begin
          low_idx[ph] = SlotW'(i);
        end
      end
    end
  end

  // Earliest phase with work left goes first.
  always_comb begin
    priority if (hit[dlu_pkg::PH_START_LOCK]) begin
      sel_ph = dlu_pkg::PH_START_LOCK;
    end else if (hit[dlu_pkg::PH_LOCK]) begin
      sel_ph = dlu_pkg::PH_LOCK;
    end else if (hit[dlu_pkg::PH_START_UNLOCK]) begin
      sel_ph = dlu_pkg::PH_START_UNLOCK;
    end else begin
      sel_ph = dlu_pkg::PH_UNLOCK;
    end
    sel_idx                   = low_idx[sel_ph];
    mask_nxt                  = mask_r;
    mask_nxt[sel_ph][sel_idx] = 1'b0;
  end

  // The command is the tick's final event when nothing is left behind it.
  assign q_push        = busy && !q_full;
  assign q_cmd.phase   = sel_ph;
  assign q_cmd.present = pres_r[sel_idx];
  assign q_cmd.last    = (mask_nxt == '0);
  assign q_cmd.slot    = dlu_pkg::SLOT_OUT_W'(sel_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (accept) begin
      mask_r <= mask_new;
    end else if (q_push) begin
      mask_r <= mask_nxt;
    end
  end

  // Presence of the current tick.
  always_ff @(posedge clk) begin
    if (accept) begin
      pres_r <= pres;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dlu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Slot executor
// Runs one command per cycle while the event channel does not stall: reads
// the slot's dwell timer, adds the tick time, compares with the threshold,
// updates status and timer, and loads the event into the output register.
// ---------------------------------------------------------------------------
module dlu_back #(
  parameter int SLOT_COUNT = dlu_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  dlu_pkg::start_t                   start,
  input  wire logic [SLOT_COUNT-1:0]        cancel,
  input  wire logic [dlu_pkg::TIME_W-1:0]   lock_time,
  input  wire logic [dlu_pkg::TIME_W-1:0]   unlock_time,
  input  dlu_pkg::cmd_t                     q_cmd,
  input  wire logic                         q_empty,
  output logic                              q_pop,
  output dlu_pkg::status_t [SLOT_COUNT-1:0] slot_status,
  output logic                              busy,
  dlu_out_if.source                         out_chan
);

  localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SumW  = dlu_pkg::TIME_W + 1;

  dlu_pkg::status_t [SLOT_COUNT-1:0] status_r;
  logic [dlu_pkg::TIME_W-1:0]        timer_mem [SLOT_COUNT];
  logic [dlu_pkg::TIME_W-1:0]        timer_rd_r;
  logic [dlu_pkg::TICK_W-1:0]        dt_r;

  logic                              s1_valid_r;
  dlu_pkg::cmd_t                     s1_cmd_r;

  logic                              out_valid_r;
  logic [dlu_pkg::SLOT_OUT_W-1:0]    out_slot_r;
  dlu_pkg::event_kind_t              out_kind_r;
  logic [dlu_pkg::TIME_W-1:0]        out_elapsed_r;
  logic                              out_last_r;

  logic                              out_free, exec, load;
  logic [SlotW-1:0]                  wr_idx, rd_idx;
  logic [SumW-1:0]                   sum;
  dlu_pkg::event_kind_t              ev_kind;
  dlu_pkg::status_t                  st_new;
  logic [dlu_pkg::TIME_W-1:0]        timer_new;
  logic [dlu_pkg::TIME_W-1:0]        ev_elapsed;

  assign out_free = !out_valid_r || out_chan.ready;
  assign exec     = s1_valid_r && out_free;
  assign load     = !q_empty && (!s1_valid_r || exec);
  assign q_pop    = load;
  assign busy     = s1_valid_r;
  assign wr_idx   = SlotW'(s1_cmd_r.slot);
  assign rd_idx   = SlotW'(q_cmd.slot);
  assign sum      = SumW'(timer_rd_r) + SumW'(dt_r);

  assign slot_status = status_r;

  // Event and next slot state for the command in the execute stage.
  always_comb begin
    ev_kind    = dlu_pkg::EV_START_LOCK;
    st_new     = dlu_pkg::ST_IDLE;
    timer_new  = '0;
    ev_elapsed = '0;
    unique case (s1_cmd_r.phase)
      dlu_pkg::PH_START_LOCK: begin
        ev_kind = dlu_pkg::EV_START_LOCK;
        st_new  = dlu_pkg::ST_WAIT_LOCK;
      end
      dlu_pkg::PH_LOCK: begin
        if (!s1_cmd_r.present) begin
          ev_kind = dlu_pkg::EV_FINISH_UNLOCK;
          st_new  = dlu_pkg::ST_IDLE;
        end else if (sum < SumW'(lock_time)) begin
          ev_kind    = dlu_pkg::EV_LOCKING;
          st_new     = dlu_pkg::ST_WAIT_LOCK;
          timer_new  = sum[dlu_pkg::TIME_W-1:0];
          ev_elapsed = sum[dlu_pkg::TIME_W-1:0];
        end else begin
          ev_kind = dlu_pkg::EV_FINISH_LOCK;
          st_new  = dlu_pkg::ST_LOCKED;
        end
      end
      dlu_pkg::PH_START_UNLOCK: begin
        ev_kind = dlu_pkg::EV_START_UNLOCK;
        st_new  = dlu_pkg::ST_WAIT_UNLOCK;
      end
      dlu_pkg::PH_UNLOCK: begin
        if (sum < SumW'(unlock_time)) begin
          ev_kind    = dlu_pkg::EV_UNLOCKING;
          st_new     = dlu_pkg::ST_WAIT_UNLOCK;
          timer_new  = sum[dlu_pkg::TIME_W-1:0];
          ev_elapsed = sum[dlu_pkg::TIME_W-1:0];
        end else begin
          ev_kind = dlu_pkg::EV_FINISH_UNLOCK;
          st_new  = dlu_pkg::ST_IDLE;
        end
      end
      default: begin
        ev_kind = dlu_pkg::EV_START_LOCK;
      end
    endcase
  end

  // Slot status; a tick start applies the silent unlock cancellations.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= {SLOT_COUNT{dlu_pkg::ST_IDLE}};
    end else if (start.go) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (cancel[i]) begin
          status_r[i] <= dlu_pkg::ST_LOCKED;
        end
      end
    end else if (exec) begin
      status_r[wr_idx] <= st_new;
    end
  end

  // Execute stage and output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_r <= 1'b1;
      end else if (exec) begin
        s1_valid_r <= 1'b0;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (start.go) begin
      dt_r <= start.dt;
    end
    if (load) begin
      s1_cmd_r <= q_cmd;
    end
    if (exec) begin
      out_slot_r    <= s1_cmd_r.slot;
      out_kind_r    <= ev_kind;
      out_elapsed_r <= ev_elapsed;
      out_last_r    <= s1_cmd_r.last;
    end
  end

  // Dwell timer memory; a read of the slot being written takes the new value.
  always_ff @(posedge clk) begin
    if (exec) begin
      timer_mem[wr_idx] <= timer_new;
    end
    if (load) begin
      if (exec && (wr_idx == rd_idx)) begin
        timer_rd_r <= timer_new;
      end else begin
        timer_rd_r <= timer_mem[rd_idx];
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.slot       = out_slot_r;
  assign out_chan.event_kind = out_kind_r;
  assign out_chan.elapsed    = out_elapsed_r;
  assign out_chan.last       = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/dwell_lock_unlock_qualifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each tick transaction carries a presence mask and the tick time; the block
// answers with zero to thirty-two event transactions, ordered start-lock,
// lock progress, start-unlock, unlock progress and by ascending slot within
// each group, the final one flagged by last. With the event channel always
// ready, the classifier issues one command per cycle, the executor retires
// one per cycle with one timer read and one timer write, and the next tick is
// taken once the executor has drained the command queue (the last event may
// still sit in the output register). A stall on the event channel holds the
// executor. lock_time and unlock_time reset to 1000 ms and should be written
// only while no tick is in flight.
// ---------------------------------------------------------------------------
// Dwell lock/unlock qualifier
// Per-slot dwell-time debouncer with a classifying front end, a command
// queue and a timer executor.
// ---------------------------------------------------------------------------
module dwell_lock_unlock_qualifier #(
  parameter int SLOT_COUNT = dlu_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  dlu_in_if.sink                                 in_chan,
  dlu_out_if.source                              out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [dlu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dlu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [dlu_pkg::TIME_W-1:0]        lock_time_r;
  logic [dlu_pkg::TIME_W-1:0]        unlock_time_r;

  dlu_pkg::status_t [SLOT_COUNT-1:0] slot_status;
  logic [SLOT_COUNT-1:0]             cancel;
  dlu_pkg::start_t                   start;
  dlu_pkg::cmd_t                     push_cmd, pop_cmd;
  logic                              q_push, q_pop, q_full, q_empty;
  logic                              back_busy, back_idle;

  assign back_idle = q_empty && !back_busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_time_r   <= dlu_pkg::LOCK_TIME_RST;
      unlock_time_r <= dlu_pkg::UNLOCK_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlu_pkg::REG_LOCK_TIME:   lock_time_r   <= cfg_wdata;
        dlu_pkg::REG_UNLOCK_TIME: unlock_time_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dlu_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .slot_status (slot_status),
    .back_idle   (back_idle),
    .start       (start),
    .cancel      (cancel),
    .q_push      (q_push),
    .q_cmd       (push_cmd),
    .q_full      (q_full)
  );

  dlu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  dlu_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .cancel      (cancel),
    .lock_time   (lock_time_r),
    .unlock_time (unlock_time_r),
    .q_cmd       (pop_cmd),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .slot_status (slot_status),
    .busy        (back_busy),
    .out_chan    (out_chan)
  );

`ifndef ASSERT_OFF
  // A new tick only starts once every command of the previous one has run.
  a_tick_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> (q_empty && !back_busy))
    else $error("tick accepted while commands were still pending");

  // The classifier never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // The executor never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command queue underflow");

  // Silent unlock cancellations are applied only at the start of a tick.
  a_cancel_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (|cancel) |-> start.go)
    else $error("unlock cancellation outside a tick start");
`endif

endmodule

`default_nettype wire
